// ----- hw/rtl/stochastic_sis_agent_update_top_assert.svh -----
// Assertion macros shared by the stochastic SIS agent update RTL.
`ifndef STOCHASTIC_SIS_AGENT_UPDATE_TOP_ASSERT_SVH
`define STOCHASTIC_SIS_AGENT_UPDATE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SISU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sisu assertion failed");
`define SISU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sisu assertion failed");
`else
`define SISU_ASSERT_IMP(label, clk, rst, ante, cons)
`define SISU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/sisu_pkg.sv -----
// Shared constants for the stochastic SIS agent update block.
package sisu_pkg;

   localparam int POP_W      = 11;
   localparam int FRAC_W     = 24;
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_POPULATION     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INFECTION_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVERY_PROB  = 2'd2;

   // Command codes of the request channel.
   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   // Register reset values.
   localparam logic [POP_W-1:0]  POPULATION_RST     = 11'd100;
   localparam logic [FRAC_W-1:0] INFECTION_RATE_RST = 24'd16777;
   localparam logic [FRAC_W-1:0] RECOVERY_PROB_RST  = 24'd167772;

   // 1.0 in Q0.24, one bit wider than a fraction.
   localparam logic [FRAC_W:0] ONE_Q24 = 25'h1000000;

endpackage

// ----- hw/rtl/sisu_req_if.sv -----
// Request channel interface: command and per-agent random sample.
interface sisu_req_if;
   import sisu_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [FRAC_W-1:0] random_fraction;
   logic [CNT_W-1:0]  initial_infected;

   modport source (output valid, cmd, random_fraction, initial_infected, input ready);
   modport sink   (input valid, cmd, random_fraction, initial_infected, output ready);
endinterface

// ----- hw/rtl/sisu_rsp_if.sv -----
// Response channel interface: updated agent and running counts.
interface sisu_rsp_if;
   import sisu_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] agent_index;
   logic             agent_infected;
   logic [CNT_W-1:0] susceptible_count;
   logic [CNT_W-1:0] infected_count;
   logic             tick_done;

   modport source (output valid, agent_index, agent_infected, susceptible_count,
                   infected_count, tick_done, input ready);
   modport sink   (input valid, agent_index, agent_infected, susceptible_count,
                   infected_count, tick_done, output ready);
endinterface

// ----- hw/rtl/sisu_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module sisu_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/stochastic_sis_agent_update_top.sv -----
// Stochastic SIS agent update block: one state bit per agent kept in a RAM.
//
// Usage: the request channel (req_if) carries a restart or an update command.
// An update visits the next agent of the sweep with one Q0.24 random sample;
// a restart sets the initial infected agents. Every request transaction gives
// exactly one response transaction on rsp_if with the agent index, its new
// state, the susceptible and infected counts, and an end-of-tick flag.
// The csr_ port writes population, infection rate and recovery probability;
// the user must write it only while the block is idle; it is not enforced.
//
// Flow: an update reads the agent RAM when it is accepted, then does the
// compare and write-back and registers its response. A restart registers
// its response and then rewrites the whole agent RAM, one entry a cycle,
// during which no request is taken. After reset the same pass runs to
// clear all agents to susceptible.
// When the receiver stalls, the response waits in the output register while
// one further request is accepted and held until that register frees.
`include "stochastic_sis_agent_update_top_assert.svh"

module stochastic_sis_agent_update_top #(
   parameter int MAX_AGENTS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   sisu_req_if.sink                           req_if,
   sisu_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [sisu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sisu_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import sisu_pkg::*;

   localparam int AW = $clog2(MAX_AGENTS);
   localparam int CW = $clog2(MAX_AGENTS + 1);
   localparam int EW = (CW > POP_W) ? CW : POP_W;
   localparam int PW = FRAC_W + EW;
   localparam logic [EW-1:0] MAX_C   = EW'(MAX_AGENTS);
   localparam logic [AW-1:0] LAST_AD = AW'(MAX_AGENTS - 1);

   localparam logic [1:0] S_FILL = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   // Configuration registers.
   logic [POP_W-1:0]  population_ff;
   logic [FRAC_W-1:0] infection_rate_ff;
   logic [FRAC_W-1:0] recovery_prob_ff;

   // Control and model state.
   logic [1:0]    state_ff, state_in;
   logic [EW-1:0] infected_total_ff, infected_total_in;
   logic [EW-1:0] tick_start_ff, tick_start_in;
   logic [EW-1:0] sweep_ff, sweep_in;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;
   logic [EW-1:0] fill_lo_ff, fill_lo_in;
   logic [EW-1:0] fill_hi_ff, fill_hi_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Captured request and precomputed infection threshold.
   logic              cmd_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [CNT_W-1:0]  init_ff;
   logic [EW-1:0]     pos_ff;
   logic [FRAC_W:0]   thresh_ff, thresh_in;

   // Response payload registers.
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_inf_ff, rsp_inf_in;
   logic [CNT_W-1:0] rsp_sus_ff, rsp_sus_in;
   logic [CNT_W-1:0] rsp_tot_ff, rsp_tot_in;
   logic             rsp_done_ff, rsp_done_in;

   logic [EW-1:0] pop_ext, eff_pop, pos_sel, n_clip, tot_upd, count_out, sus_val;
   logic [PW-1:0] prod;
   logic          req_acc, slot_free, emit;
   logic          cur_st, new_st, flip, recover, last;
   logic          ram_we, ram_wd, ram_rd;
   logic [AW-1:0] ram_wa;

   always_ff @(posedge clock) begin
      if (reset) begin
         population_ff     <= POPULATION_RST;
         infection_rate_ff <= INFECTION_RATE_RST;
         recovery_prob_ff  <= RECOVERY_PROB_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_POPULATION:     population_ff     <= csr_wdata[POP_W-1:0];
            REG_INFECTION_RATE: infection_rate_ff <= csr_wdata[FRAC_W-1:0];
            REG_RECOVERY_PROB:  recovery_prob_ff  <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pop_ext = EW'(population_ff);
      if (pop_ext == '0) begin
         eff_pop = EW'(1);
      end else if (pop_ext > MAX_C) begin
         eff_pop = MAX_C;
      end else begin
         eff_pop = pop_ext;
      end
   end

   // The snapshot only moves at the end of a tick or on a restart, so the saturated
   // product is computed from it and registered before the next update uses it.
   always_comb begin
      prod = PW'(infection_rate_ff) * PW'(tick_start_ff);
      if (prod > PW'(ONE_Q24)) begin
         thresh_in = ONE_Q24;
      end else begin
         thresh_in = prod[FRAC_W:0];
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign pos_sel      = (sweep_ff >= eff_pop) ? '0 : sweep_ff;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign emit         = (state_ff == S_EXEC) && slot_free;
   assign ram_rd       = req_acc;

   sisu_ram #(
      .WIDTH (1),
      .DEPTH (MAX_AGENTS)
   ) u_agent_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_rd),
      .rd_addr (pos_sel[AW-1:0]),
      .rd_data (cur_st)
   );

   always_comb begin
      flip    = ({1'b0, frac_ff} < thresh_ff);
      recover = (frac_ff < recovery_prob_ff);
      tot_upd = infected_total_ff;
      if (!cur_st) begin
         new_st = flip;
         if (flip && (infected_total_ff < MAX_C)) begin
            tot_upd = infected_total_ff + EW'(1);
         end
      end else begin
         new_st = !recover;
         if (recover && (infected_total_ff != '0)) begin
            tot_upd = infected_total_ff - EW'(1);
         end
      end
      last      = ({1'b0, pos_ff} + (EW+1)'(1)) >= {1'b0, eff_pop};
      n_clip    = (EW'(init_ff) > eff_pop) ? eff_pop : EW'(init_ff);
      count_out = (cmd_ff == CMD_RESTART) ? n_clip : tot_upd;
      sus_val   = (eff_pop > count_out) ? (eff_pop - count_out) : '0;
   end

   always_comb begin
      ram_we = 1'b0;
      ram_wa = pos_ff[AW-1:0];
      ram_wd = new_st;
      if (state_ff == S_FILL) begin
         ram_we = 1'b1;
         ram_wa = fill_addr_ff;
         ram_wd = (EW'(fill_addr_ff) >= fill_lo_ff) && (EW'(fill_addr_ff) < fill_hi_ff);
      end else if (emit && (cmd_ff == CMD_UPDATE)) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      state_in          = state_ff;
      infected_total_in = infected_total_ff;
      tick_start_in     = tick_start_ff;
      sweep_in          = sweep_ff;
      fill_addr_in      = fill_addr_ff;
      fill_lo_in        = fill_lo_ff;
      fill_hi_in        = fill_hi_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_if.ready;
      rsp_index_in      = rsp_index_ff;
      rsp_inf_in        = rsp_inf_ff;
      rsp_sus_in        = rsp_sus_ff;
      rsp_tot_in        = rsp_tot_ff;
      rsp_done_in       = rsp_done_ff;

      case (state_ff)
         S_FILL: begin
            fill_addr_in = fill_addr_ff + AW'(1);
            if (fill_addr_ff == LAST_AD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_sus_in   = sus_val[CNT_W-1:0];
               rsp_tot_in   = count_out[CNT_W-1:0];
               if (cmd_ff == CMD_RESTART) begin
                  rsp_index_in      = '0;
                  rsp_inf_in        = 1'b0;
                  rsp_done_in       = 1'b0;
                  infected_total_in = n_clip;
                  tick_start_in     = n_clip;
                  sweep_in          = '0;
                  fill_lo_in        = eff_pop - n_clip;
                  fill_hi_in        = eff_pop;
                  fill_addr_in      = '0;
                  state_in          = S_FILL;
               end else begin
                  rsp_index_in      = pos_ff[IDX_W-1:0];
                  rsp_inf_in        = new_st;
                  rsp_done_in       = last;
                  infected_total_in = tot_upd;
                  if (last) begin
                     sweep_in      = '0;
                     tick_start_in = tot_upd;
                  end else begin
                     sweep_in = pos_ff + EW'(1);
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_FILL;
         infected_total_ff <= '0;
         tick_start_ff     <= '0;
         sweep_ff          <= '0;
         fill_addr_ff      <= '0;
         fill_lo_ff        <= '0;
         fill_hi_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         infected_total_ff <= infected_total_in;
         tick_start_ff     <= tick_start_in;
         sweep_ff          <= sweep_in;
         fill_addr_ff      <= fill_addr_in;
         fill_lo_ff        <= fill_lo_in;
         fill_hi_ff        <= fill_hi_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      thresh_ff    <= thresh_in;
      rsp_index_ff <= rsp_index_in;
      rsp_inf_ff   <= rsp_inf_in;
      rsp_sus_ff   <= rsp_sus_in;
      rsp_tot_ff   <= rsp_tot_in;
      rsp_done_ff  <= rsp_done_in;
      if (req_acc) begin
         cmd_ff  <= req_if.cmd;
         frac_ff <= req_if.random_fraction;
         init_ff <= req_if.initial_infected;
         pos_ff  <= pos_sel;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.agent_index       = rsp_index_ff;
   assign rsp_if.agent_infected    = rsp_inf_ff;
   assign rsp_if.susceptible_count = rsp_sus_ff;
   assign rsp_if.infected_count    = rsp_tot_ff;
   assign rsp_if.tick_done         = rsp_done_ff;

   `SISU_ASSERT_IMP(a_total_range, clock, reset, 1'b1, infected_total_ff <= MAX_C)
   `SISU_ASSERT_NEXT(a_accept_exec, clock, reset, req_acc, state_ff == S_EXEC)
   `SISU_ASSERT_NEXT(a_restart_fill, clock, reset, emit && (cmd_ff == CMD_RESTART), (state_ff == S_FILL) && (fill_addr_ff == '0))
   `SISU_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_EXEC)
endmodule

// ----- dv/tb_stochastic_sis_agent_update_top.sv -----
// Self-checking testbench for the stochastic SIS agent update block.
module tb_stochastic_sis_agent_update_top;
   import sisu_pkg::*;

   localparam int MAX_AGENTS   = 1024;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int QUIET_CYCLES = MAX_AGENTS + 16;
   localparam int N_PHASES     = 12;
   localparam int PHASE_ITEMS  = 75;
   localparam int PLAN_LEN     = 30;

   typedef struct packed {
      logic [IDX_W-1:0] agent_index;
      logic             agent_infected;
      logic [CNT_W-1:0] susceptible_count;
      logic [CNT_W-1:0] infected_count;
      logic             tick_done;
   } sis_result_type;

   // One row of the directed plan: either a register write or a transaction.
   typedef struct packed {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      logic                  cmd;
      logic [FRAC_W-1:0]     frac;
      logic [CNT_W-1:0]      init_inf;
      bit                    typed;
      sis_result_type        want;
   } plan_row_type;

   localparam sis_result_type NO_RESULT = '0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sisu_req_if req ();
   sisu_rsp_if rsp ();

   stochastic_sis_agent_update_top #(
      .MAX_AGENTS(MAX_AGENTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req),
      .rsp_if   (rsp),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the block state and registers.
   bit                agent_bits [MAX_AGENTS];
   int unsigned       infected_now;
   int unsigned       infected_snapshot;
   int unsigned       sweep_pos;
   logic [POP_W-1:0]  pop_reg;
   logic [FRAC_W-1:0] rate_reg;
   logic [FRAC_W-1:0] recovery_reg;

   sis_result_type expected_results [$];
   int             errors = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int unsigned    cycle_count = 0;

   plan_row_type plan [PLAN_LEN] = '{
      // Update before any restart: everyone is susceptible and nobody can infect.
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd0, 11'd0,
        1'b1, '{10'd0, 1'b0, 11'd100, 11'd0, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'd0, 11'd0,
        1'b1, '{10'd0, 1'b0, 11'd100, 11'd0, 1'b0}},
      // Initial infected far above the population is clipped.
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'hFFFFFF, 11'd2047,
        1'b1, '{10'd0, 1'b0, 11'd0, 11'd100, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd0, 11'd0,
        1'b1, '{10'd0, 1'b0, 11'd1, 11'd99, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd1, 1'b1, 11'd1, 11'd99, 1'b0}},
      // Recovery threshold from just below and exactly at it.
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd167771, 11'd0,
        1'b1, '{10'd2, 1'b0, 11'd2, 11'd98, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd167772, 11'd0,
        1'b1, '{10'd3, 1'b1, 11'd2, 11'd98, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'd0, 11'd1,
        1'b1, '{10'd0, 1'b0, 11'd99, 11'd1, 1'b0}},
      // Infection threshold from just below and exactly at it.
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd16776, 11'd0,
        1'b1, '{10'd0, 1'b1, 11'd98, 11'd2, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd16777, 11'd0,
        1'b1, '{10'd1, 1'b0, 11'd98, 11'd2, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'd0, 11'd1024,
        1'b1, '{10'd0, 1'b0, 11'd0, 11'd100, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'h123456, 11'd50, 1'b0, NO_RESULT},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'h5A5A5A, 11'd0, 1'b0, NO_RESULT},
      // A population register of zero behaves as a single agent.
      '{1'b1, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd0, 11'd0, 1'b0, NO_RESULT},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'd0, 11'd5,
        1'b1, '{10'd0, 1'b0, 11'd0, 11'd1, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd0, 1'b1, 11'd0, 11'd1, 1'b1}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd0, 11'd0,
        1'b1, '{10'd0, 1'b0, 11'd1, 11'd0, 1'b1}},
      // Full infection rate with two infected saturates the product at one.
      '{1'b1, REG_INFECTION_RATE, 24'hFFFFFF, CMD_UPDATE, 24'd0, 11'd0, 1'b0, NO_RESULT},
      '{1'b1, REG_POPULATION, 24'd4, CMD_UPDATE, 24'd0, 11'd0, 1'b0, NO_RESULT},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'd0, 11'd2,
        1'b1, '{10'd0, 1'b0, 11'd2, 11'd2, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd0, 1'b1, 11'd1, 11'd3, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd1, 1'b1, 11'd0, 11'd4, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd2, 1'b1, 11'd0, 11'd4, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd0, 11'd0,
        1'b1, '{10'd3, 1'b0, 11'd1, 11'd3, 1'b1}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd0, 1'b1, 11'd1, 11'd3, 1'b0}},
      // Shrinking the population behind the sweep wraps it to agent zero and
      // leaves more infected than agents, so the susceptible count floors.
      '{1'b1, REG_POPULATION, 24'd1, CMD_UPDATE, 24'd0, 11'd0, 1'b0, NO_RESULT},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'hFFFFFF, 11'd0,
        1'b1, '{10'd0, 1'b1, 11'd0, 11'd3, 1'b1}},
      // An oversized population register is capped at the agent capacity.
      '{1'b1, REG_POPULATION, 24'd2047, CMD_UPDATE, 24'd0, 11'd0, 1'b0, NO_RESULT},
      '{1'b0, REG_POPULATION, 24'd0, CMD_RESTART, 24'd0, 11'd2047,
        1'b1, '{10'd0, 1'b0, 11'd0, 11'd1024, 1'b0}},
      '{1'b0, REG_POPULATION, 24'd0, CMD_UPDATE, 24'd0, 11'd0,
        1'b1, '{10'd0, 1'b0, 11'd1, 11'd1023, 1'b0}}
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned active_agents();
      if (pop_reg == '0)
         return 1;
      if (pop_reg > MAX_AGENTS)
         return MAX_AGENTS;
      return pop_reg;
   endfunction

   // Probability, in Q0.24 with one extra bit for 1.0, that the agent flips.
   function automatic logic [FRAC_W:0] flip_threshold(int unsigned pos);
      longint unsigned prod;
      if (agent_bits[pos])
         return {1'b0, recovery_reg};
      prod = longint'(rate_reg) * longint'(infected_snapshot);
      if (prod > ONE_Q24)
         return ONE_Q24;
      return prod[FRAC_W:0];
   endfunction

   function automatic sis_result_type sis_step(logic cmd, logic [FRAC_W-1:0] frac,
                                               logic [CNT_W-1:0] init_inf);
      int unsigned    pop;
      int unsigned    n;
      int unsigned    pos;
      bit             st;
      bit             done;
      sis_result_type res;
      pop  = active_agents();
      done = 1'b0;
      if (cmd == CMD_RESTART) begin
         n = (init_inf > pop) ? pop : init_inf;
         for (int i = 0; i < MAX_AGENTS; i++)
            agent_bits[i] = (i >= pop - n) && (i < pop);
         infected_now      = n;
         infected_snapshot = n;
         sweep_pos         = 0;
         pos               = 0;
         st                = 1'b0;
      end else begin
         pos = (sweep_pos >= pop) ? 0 : sweep_pos;
         st  = agent_bits[pos];
         if (frac < flip_threshold(pos)) begin
            if (!st) begin
               if (infected_now < MAX_AGENTS)
                  infected_now++;
            end else if (infected_now > 0) begin
               infected_now--;
            end
            st = !st;
         end
         agent_bits[pos] = st;
         if (pos + 1 >= pop) begin
            done              = 1'b1;
            sweep_pos         = 0;
            infected_snapshot = infected_now;
         end else begin
            sweep_pos = pos + 1;
         end
      end
      res.agent_index       = pos[IDX_W-1:0];
      res.agent_infected    = st;
      res.susceptible_count = (pop > infected_now) ? CNT_W'(pop - infected_now) : '0;
      res.infected_count    = infected_now[CNT_W-1:0];
      res.tick_done         = done;
      return res;
   endfunction

   task automatic report_field(string field, int unsigned want, int unsigned got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   task automatic check_result(sis_result_type got);
      sis_result_type want;
      if (expected_results.size() == 0) begin
         errors++;
         $display("%0t: unexpected transaction, expected none actual %h", $time, got);
         return;
      end
      want = expected_results.pop_front();
      if (got.agent_index !== want.agent_index)
         report_field("agent_index", want.agent_index, got.agent_index);
      if (got.agent_infected !== want.agent_infected)
         report_field("agent_infected", want.agent_infected, got.agent_infected);
      if (got.susceptible_count !== want.susceptible_count)
         report_field("susceptible_count", want.susceptible_count, got.susceptible_count);
      if (got.infected_count !== want.infected_count)
         report_field("infected_count", want.infected_count, got.infected_count);
      if (got.tick_done !== want.tick_done)
         report_field("tick_done", want.tick_done, got.tick_done);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready)
            check_result(sis_result_type'{rsp.agent_index, rsp.agent_infected,
                                          rsp.susceptible_count, rsp.infected_count,
                                          rsp.tick_done});
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sends one transaction and records its expected response once accepted.
   task automatic drive_request(logic cmd, logic [FRAC_W-1:0] frac,
                                logic [CNT_W-1:0] init_inf, bit typed,
                                sis_result_type want);
      sis_result_type predicted;
      sis_result_type queued;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid            <= 1'b1;
      req.cmd              <= cmd;
      req.random_fraction  <= frac;
      req.initial_infected <= init_inf;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      predicted        = sis_step(cmd, frac, init_inf);
      queued           = typed ? want : predicted;
      expected_results = {expected_results, queued};
   endtask

   // The block rewrites its agent RAM after a restart, so registers only
   // change once all responses are in and that pass has had time to finish.
   task automatic wait_quiet();
      req.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_POPULATION:     pop_reg      = val[POP_W-1:0];
         REG_INFECTION_RATE: rate_reg     = val[FRAC_W-1:0];
         REG_RECOVERY_PROB:  recovery_reg = val[FRAC_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
         1: begin send_idle_pct = 74; recv_stall_pct <= 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct <= 74; end
         default: begin send_idle_pct = 20; recv_stall_pct <= 20; end
      endcase
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] new_pop;
      logic [CSR_DATA_W-1:0] new_rate;
      logic [CSR_DATA_W-1:0] new_rec;
      logic [FRAC_W-1:0]     frac;
      logic [CNT_W-1:0]      init_inf;
      logic [FRAC_W:0]       thr;
      longint                near;
      int unsigned           pos;

      reset                <= 1'b1;
      req.valid            <= 1'b0;
      req.cmd              <= CMD_UPDATE;
      req.random_fraction  <= '0;
      req.initial_infected <= '0;
      csr_we               <= 1'b0;
      csr_index            <= REG_POPULATION;
      csr_wdata            <= '0;

      pop_reg           = POPULATION_RST;
      rate_reg          = INFECTION_RATE_RST;
      recovery_reg      = RECOVERY_PROB_RST;
      infected_now      = 0;
      infected_snapshot = 0;
      sweep_pos         = 0;
      foreach (agent_bits[i])
         agent_bits[i] = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            wait_quiet();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            drive_request(plan[i].cmd, plan[i].frac, plan[i].init_inf,
                          plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: begin new_pop = 24'd2047; new_rate = '0; new_rec = '0; end
            1: begin new_pop = 24'd0; new_rate = 24'hFFFFFF; new_rec = 24'hFFFFFF; end
            2: begin
               new_pop  = 24'd1024;
               new_rate = CSR_DATA_W'(($urandom() & 24'hFFFFFF) >> 10);
               new_rec  = CSR_DATA_W'(($urandom() & 24'hFFFFFF) >> 6);
            end
            default: begin
               // Mostly small populations so that sweeps end often.
               new_pop  = CSR_DATA_W'(($urandom_range(3) != 0) ? $urandom_range(1, 12)
                                                               : $urandom_range(13, 200));
               new_rate = CSR_DATA_W'(($urandom() & 24'hFFFFFF) >> $urandom_range(0, 12));
               new_rec  = CSR_DATA_W'(($urandom() & 24'hFFFFFF) >> $urandom_range(0, 8));
            end
         endcase
         wait_quiet();
         write_reg(REG_POPULATION, new_pop);
         write_reg(REG_INFECTION_RATE, new_rate);
         write_reg(REG_RECOVERY_PROB, new_rec);
         set_idling(p % 4);

         // Every third phase keeps the previous run going across the change.
         if (p % 3 != 2)
            drive_request(CMD_RESTART, FRAC_W'($urandom()),
                          CNT_W'($urandom_range(0, active_agents())), 1'b0, NO_RESULT);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) < 5) begin
               init_inf = CNT_W'($urandom_range(1) ? $urandom_range(0, active_agents())
                                                   : $urandom_range(0, 2047));
               drive_request(CMD_RESTART, FRAC_W'($urandom()), init_inf, 1'b0, NO_RESULT);
            end else begin
               pos = (sweep_pos >= active_agents()) ? 0 : sweep_pos;
               thr = flip_threshold(pos);
               case ($urandom_range(3))
                  0: frac = FRAC_W'($urandom());
                  1: begin
                     // Land on or right beside the flip threshold of the agent up next.
                     near = longint'(thr) + longint'($urandom_range(2)) - 1;
                     if (near < 0)
                        near = 0;
                     if (near > 24'hFFFFFF)
                        near = 24'hFFFFFF;
                     frac = near[FRAC_W-1:0];
                  end
                  2: frac = FRAC_W'($urandom_range(0, 255));
                  default: frac = 24'hFFFFFF - FRAC_W'($urandom_range(0, 255));
               endcase
               drive_request(CMD_UPDATE, frac, CNT_W'($urandom()), 1'b0, NO_RESULT);
            end
         end
      end

      req.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
